[rtl/rtt_pkg.sv]
// shared types, codes and defaults for the request timeout tracker
// no dependencies; used by rtt_front, rtt_engine and request_timeout_tracker_unit
`timescale 1ns / 1ps

package rtt_pkg;

	// field widths of the external channels
	localparam int RAW_ID_BITS = 6;
	localparam int RAW_ID_COUNT = 64;
	localparam int STAMP_BITS = 32;
	localparam int KIND_BITS = 2;

	// parameter defaults
	localparam int DEF_ID_COUNT = 64;
	localparam int DEF_QUEUE_DEPTH = 32;
	localparam int DEF_TIME_BITS = 32;

	localparam logic [STAMP_BITS-1:0] TIMEOUT_RESET = 32'd3;

	// operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_END = 1'b1;

	// result kinds
	localparam logic [KIND_BITS-1:0] KIND_TIMEOUT = 2'd0;
	localparam logic [KIND_BITS-1:0] KIND_DONE = 2'd1;
	localparam logic [KIND_BITS-1:0] KIND_DROPPED = 2'd2;

	typedef struct packed {
		logic operation;
		logic [RAW_ID_BITS-1:0] request_id;
		logic [STAMP_BITS-1:0] timestamp;
	} evt_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] result_kind;
		logic [RAW_ID_BITS-1:0] expired_id;
		logic [STAMP_BITS-1:0] detect_time;
		logic last_of_run;
	} res_t;

	// back end to front end control
	typedef struct packed {
		logic pop;
		logic clearing;
	} eng_ctl_t;

endpackage

[rtl/rtt_ram.sv]
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rtt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[rtl/rtt_front.sv]
// front end: takes requests, folds the id into range, holds them in a short queue
// depends on rtt_pkg
`timescale 1ns / 1ps

module rtt_front #(
	parameter int ID_COUNT = rtt_pkg::DEF_ID_COUNT,
	parameter int TIME_BITS = rtt_pkg::DEF_TIME_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        evt_valid,
	output logic                        evt_stall,
	input  rtt_pkg::evt_t               evt_data,
	input  rtt_pkg::eng_ctl_t           ctl,
	output logic                        cmd_valid,
	output logic                        cmd_op,
	output logic [$clog2(ID_COUNT)-1:0] cmd_id,
	output logic [TIME_BITS-1:0]        cmd_time
);

	localparam int IDW = $clog2(ID_COUNT);

	typedef logic [IDW-1:0] id_map_t [rtt_pkg::RAW_ID_COUNT];

	function automatic id_map_t build_map();
		id_map_t m;
		for (int i = 0; i < rtt_pkg::RAW_ID_COUNT; i++) begin
			m[i] = IDW'(i % ID_COUNT);
		end
		return m;
	endfunction

	localparam id_map_t ID_MAP = build_map();

	logic                 slot_op_q   [2];
	logic [IDW-1:0]       slot_id_q   [2];
	logic [TIME_BITS-1:0] slot_time_q [2];
	logic                 wr_ptr_q;
	logic                 rd_ptr_q;
	logic [1:0]           fill_q;
	logic                 push;

	assign evt_stall = (fill_q == 2'd2) || ctl.clearing;
	assign push = evt_valid && !evt_stall;

	assign cmd_valid = (fill_q != 2'd0);
	assign cmd_op = slot_op_q[rd_ptr_q];
	assign cmd_id = slot_id_q[rd_ptr_q];
	assign cmd_time = slot_time_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_op_q[wr_ptr_q] <= evt_data.operation;
			slot_id_q[wr_ptr_q] <= ID_MAP[evt_data.request_id];
			slot_time_q[wr_ptr_q] <= TIME_BITS'(evt_data.timestamp);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (ctl.pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !ctl.pop) begin
				fill_q <= fill_q + 2'd1;
			end else if (!push && ctl.pop) begin
				fill_q <= fill_q - 2'd1;
			end
		end
	end

endmodule

[rtl/rtt_engine.sv]
// back end: drains the start-order queue, applies each request, drives the result register
// depends on rtt_pkg and rtt_ram
`timescale 1ns / 1ps

module rtt_engine #(
	parameter int ID_COUNT = rtt_pkg::DEF_ID_COUNT,
	parameter int QUEUE_DEPTH = rtt_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS = rtt_pkg::DEF_TIME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [rtt_pkg::STAMP_BITS-1:0]   timeout,
	input  logic                             cmd_valid,
	input  logic                             cmd_op,
	input  logic [$clog2(ID_COUNT)-1:0]      cmd_id,
	input  logic [TIME_BITS-1:0]             cmd_time,
	output rtt_pkg::eng_ctl_t                ctl,
	output logic                             res_valid,
	input  logic                             res_stall,
	output rtt_pkg::res_t                    res_data
);

	localparam int IDW = $clog2(ID_COUNT);
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int TW = TIME_BITS + 1;
	localparam int CMPW = (TIME_BITS > rtt_pkg::STAMP_BITS) ? TIME_BITS : rtt_pkg::STAMP_BITS;

	localparam logic [2:0] ST_CLEAR   = 3'd0;
	localparam logic [2:0] ST_IDLE    = 3'd1;
	localparam logic [2:0] ST_FIFO_RD = 3'd2;
	localparam logic [2:0] ST_TBL_RD  = 3'd3;
	localparam logic [2:0] ST_APPLY   = 3'd4;

	logic [2:0]           state_q, state_n;
	logic [IDW-1:0]       clr_q;
	logic                 ev_op_q;
	logic [IDW-1:0]       ev_id_q;
	logic [TIME_BITS-1:0] ev_time_q;
	logic [HW-1:0]        head_q, head_nxt;
	logic [HW-1:0]        tail_q, tail_nxt;
	logic [CW-1:0]        count_q;
	logic                 res_valid_q;
	rtt_pkg::res_t        res_q, res_n;

	logic                 tbl_wr_en, tbl_rd_en;
	logic [IDW-1:0]       tbl_wr_addr;
	logic [TW-1:0]        tbl_wr_data, tbl_rd_data;
	logic                 fifo_rd_en;
	logic [HW-1:0]        fifo_rd_addr;
	logic [IDW-1:0]       fifo_rd_data;

	logic                 tbl_pend;
	logic [TIME_BITS-1:0] tbl_start, age;
	logic                 is_expired, out_free, take_cmd;
	logic                 report, discard, pop_fifo, finish, is_start, drop, push;

	rtt_ram #(
		.WIDTH (TW),
		.DEPTH (ID_COUNT)
	) u_time_tbl (
		.clk     (clk),
		.wr_en   (tbl_wr_en),
		.wr_addr (tbl_wr_addr),
		.wr_data (tbl_wr_data),
		.rd_en   (tbl_rd_en),
		.rd_addr (fifo_rd_data),
		.rd_data (tbl_rd_data)
	);

	rtt_ram #(
		.WIDTH (IDW),
		.DEPTH (QUEUE_DEPTH)
	) u_order_fifo (
		.clk     (clk),
		.wr_en   (push),
		.wr_addr (tail_q),
		.wr_data (ev_id_q),
		.rd_en   (fifo_rd_en),
		.rd_addr (fifo_rd_addr),
		.rd_data (fifo_rd_data)
	);

	always_comb begin
		head_nxt = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
		tail_nxt = (tail_q == HW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

		tbl_pend = tbl_rd_data[TIME_BITS];
		tbl_start = tbl_rd_data[TIME_BITS-1:0];
		// wrapping age, compared at the wider of time and timeout width
		age = ev_time_q - tbl_start;
		is_expired = (CMPW'(age) > CMPW'(timeout));

		out_free = !res_valid_q || !res_stall;
		take_cmd = (state_q == ST_IDLE) && cmd_valid;
		report = (state_q == ST_TBL_RD) && tbl_pend && is_expired && out_free;
		discard = (state_q == ST_TBL_RD) && !tbl_pend;
		pop_fifo = report || discard;
		finish = (state_q == ST_APPLY) && out_free;
		is_start = (ev_op_q == rtt_pkg::OP_START);
		drop = is_start && (count_q == CW'(QUEUE_DEPTH));
		push = finish && is_start && !drop;

		fifo_rd_en = (take_cmd && (count_q != '0)) || (pop_fifo && (count_q > CW'(1)));
		fifo_rd_addr = (state_q == ST_IDLE) ? head_q : head_nxt;
		tbl_rd_en = (state_q == ST_FIFO_RD);

		tbl_wr_en = 1'b0;
		tbl_wr_addr = ev_id_q;
		tbl_wr_data = '0;
		if (state_q == ST_CLEAR) begin
			tbl_wr_en = 1'b1;
			tbl_wr_addr = clr_q;
		end else if (report) begin
			tbl_wr_en = 1'b1;
			tbl_wr_addr = fifo_rd_data;
			tbl_wr_data = {1'b0, tbl_start};
		end else if (finish && !drop) begin
			// start marks pending with its time, end clears pending
			tbl_wr_en = 1'b1;
			tbl_wr_data = {is_start, ev_time_q};
		end

		if (report) begin
			res_n.result_kind = rtt_pkg::KIND_TIMEOUT;
			res_n.expired_id = rtt_pkg::RAW_ID_BITS'(fifo_rd_data);
			res_n.last_of_run = 1'b0;
		end else begin
			res_n.result_kind = drop ? rtt_pkg::KIND_DROPPED : rtt_pkg::KIND_DONE;
			res_n.expired_id = '0;
			res_n.last_of_run = 1'b1;
		end
		res_n.detect_time = rtt_pkg::STAMP_BITS'(ev_time_q);

		state_n = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == IDW'(ID_COUNT - 1)) begin
					state_n = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (cmd_valid) begin
					state_n = (count_q != '0) ? ST_FIFO_RD : ST_APPLY;
				end
			end
			ST_FIFO_RD: begin
				state_n = ST_TBL_RD;
			end
			ST_TBL_RD: begin
				if (pop_fifo) begin
					state_n = (count_q > CW'(1)) ? ST_FIFO_RD : ST_APPLY;
				end else if (tbl_pend && !is_expired) begin
					state_n = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (out_free) begin
					state_n = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	assign ctl.pop = take_cmd;
	assign ctl.clearing = (state_q == ST_CLEAR);
	assign res_valid = res_valid_q;
	assign res_data = res_q;

	always_ff @(posedge clk) begin
		if (take_cmd) begin
			ev_op_q <= cmd_op;
			ev_id_q <= cmd_id;
			ev_time_q <= cmd_time;
		end
		if (report || finish) begin
			res_q <= res_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop_fifo) begin
				head_q <= head_nxt;
				count_q <= count_q - 1'b1;
			end else if (push) begin
				tail_q <= tail_nxt;
				count_q <= count_q + 1'b1;
			end
			if (report || finish) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/request_timeout_tracker_unit.sv]
// Outstanding request timeout tracker.
// Request channel evt_*: valid/stall, one start or end per request with id and time.
// Result channel res_*: valid/stall, timeout reports followed by one status result
// with last_of_run set; the result register holds while res_stall is high and the
// back end waits on it, while the front queue keeps taking up to two requests.
// Config channel cfg_*: valid/ready, writes timeout_q (always ready).
// In the back end, when the start-order queue is empty, a request goes straight to the
// apply state; else it first drains the queue, examining each drained entry and the young
// entry that stops the drain; each examined entry costs one queue ram read and one
// time-table ram read in sequence. A new result waits while res_stall holds the
// previous one in the result register, and the back end waits with it.
// After reset the time table is swept clear, one entry a cycle, with evt_stall held
// high; timeout_q resets to 3.
// Depends on rtt_pkg, rtt_front, rtt_engine, rtt_ram.
`timescale 1ns / 1ps

module request_timeout_tracker_unit #(
	parameter int ID_COUNT = rtt_pkg::DEF_ID_COUNT,
	parameter int QUEUE_DEPTH = rtt_pkg::DEF_QUEUE_DEPTH,
	parameter int TIME_BITS = rtt_pkg::DEF_TIME_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           evt_valid,
	output logic                           evt_stall,
	input  rtt_pkg::evt_t                  evt_data,
	output logic                           res_valid,
	input  logic                           res_stall,
	output rtt_pkg::res_t                  res_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [rtt_pkg::STAMP_BITS-1:0] cfg_data
);

	logic [rtt_pkg::STAMP_BITS-1:0] timeout_q;
	rtt_pkg::eng_ctl_t              ctl;
	logic                           cmd_valid;
	logic                           cmd_op;
	logic [$clog2(ID_COUNT)-1:0]    cmd_id;
	logic [TIME_BITS-1:0]           cmd_time;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= rtt_pkg::TIMEOUT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	rtt_front #(
		.ID_COUNT  (ID_COUNT),
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt_data  (evt_data),
		.ctl       (ctl),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd_op),
		.cmd_id    (cmd_id),
		.cmd_time  (cmd_time)
	);

	rtt_engine #(
		.ID_COUNT    (ID_COUNT),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TIME_BITS   (TIME_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.timeout   (timeout_q),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd_op),
		.cmd_id    (cmd_id),
		.cmd_time  (cmd_time),
		.ctl       (ctl),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

	// no request taken while the table sweep runs
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clearing |-> evt_stall)
		else $error("request accepted during table clear");

	// back end only pops a command that the front end holds
	a_pop_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> cmd_valid && !ctl.clearing)
		else $error("command popped from empty front queue");

	// timeout reports are never the final result of a request
	a_report_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_data.result_kind == rtt_pkg::KIND_TIMEOUT) |-> !res_data.last_of_run)
		else $error("timeout report flagged as last");

	// status results carry a zero id and a done or dropped kind
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.last_of_run |->
			(res_data.expired_id == '0) &&
			((res_data.result_kind == rtt_pkg::KIND_DONE) ||
			 (res_data.result_kind == rtt_pkg::KIND_DROPPED)))
		else $error("malformed status result");

endmodule
